FILE: hw/rtl/tcw_pkg.sv
// Package for the text console writer: field widths, character codes,
// action codes and the command/status bundles between control and datapath.
// No dependencies.
package tcw_pkg;

   localparam int COLUMNS_DEFAULT = 80;
   localparam int ROWS_DEFAULT    = 25;

   localparam int ACTION_W = 2;
   localparam int CHAR_W   = 8;
   localparam int ATTR_W   = 8;
   localparam int RROW_W   = 5;
   localparam int RCOL_W   = 7;
   localparam int CCOL_W   = 7;
   localparam int CROW_W   = 5;
   localparam int COFS_W   = 11;
   localparam int CELL_W   = CHAR_W + ATTR_W;

   localparam logic [CHAR_W-1:0] NL_CODE    = 8'd10;
   localparam logic [CHAR_W-1:0] TAB_CODE   = 8'd9;
   localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
   localparam logic [ATTR_W-1:0] BLANK_ATTR = 8'h07;
   localparam logic [CELL_W-1:0] BLANK_CELL = {BLANK_ATTR, BLANK_CHAR};
   localparam int TAB_STOP = 8;

   typedef enum logic [ACTION_W-1:0] {
      ACT_PUT   = 2'd0,
      ACT_READ  = 2'd1,
      ACT_CLEAR = 2'd2
   } action_type;

   typedef struct packed {
      logic take;
      logic put;
      logic rd_issue;
      logic rd_capture;
      logic cell_zero;
      logic sweep_blank;
      logic sweep_scroll;
      logic scroll_home;
      logic clear_home;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic [ACTION_W-1:0] act;
      logic                scroll_pend;
      logic                read_ok;
      logic                sweep_last;
      logic                out_free;
   } status_type;

endpackage

FILE: hw/rtl/tcw_if.sv
// Valid/ready channel interfaces for the text console writer.
// Depends on tcw_pkg for the payload widths.
interface tcw_req_if import tcw_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [CHAR_W-1:0]   char_code;
   logic [ATTR_W-1:0]   attribute;
   logic [RROW_W-1:0]   read_row;
   logic [RCOL_W-1:0]   read_col;

   modport source (output valid, action, char_code, attribute, read_row, read_col,
                   input ready);
   modport sink   (input valid, action, char_code, attribute, read_row, read_col,
                   output ready);
endinterface

interface tcw_rsp_if import tcw_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CCOL_W-1:0] cursor_column;
   logic [CROW_W-1:0] cursor_row;
   logic [COFS_W-1:0] cursor_offset;
   logic [CHAR_W-1:0] cell_char;
   logic [ATTR_W-1:0] cell_attr;

   modport source (output valid, cursor_column, cursor_row, cursor_offset, cell_char,
                   cell_attr, input ready);
   modport sink   (input valid, cursor_column, cursor_row, cursor_offset, cell_char,
                   cell_attr, output ready);
endinterface

FILE: hw/rtl/tcw_ctrl.sv
// Controller for the text console writer: sequences accept, execute,
// scroll/clear sweeps and the result transfer. Depends on tcw_pkg.
module tcw_ctrl import tcw_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [5:0] {
      ST_INIT   = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_EXEC   = 6'b000100,
      ST_READ   = 6'b001000,
      ST_SCROLL = 6'b010000,
      ST_CLEAR  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      pend_ff, pend_in;
   logic      ready;

   always_comb begin
      state_in = state_ff;
      pend_in  = pend_ff;
      cmd      = '0;
      ready    = 1'b0;
      cmd.out_load = pend_ff && status.out_free;
      if (cmd.out_load) begin
         pend_in = 1'b0;
      end
      case (state_ff)
         ST_INIT: begin
            cmd.sweep_blank = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            ready = !pend_ff || status.out_free;
            if (req_valid && ready) begin
               cmd.take = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (status.act == ACT_PUT) begin
               if (status.scroll_pend) begin
                  state_in = ST_SCROLL;
               end else begin
                  cmd.put       = 1'b1;
                  cmd.cell_zero = 1'b1;
                  pend_in       = 1'b1;
                  state_in      = ST_IDLE;
               end
            end else if (status.act == ACT_READ && status.read_ok) begin
               cmd.rd_issue = 1'b1;
               state_in     = ST_READ;
            end else if (status.act == ACT_CLEAR) begin
               state_in = ST_CLEAR;
            end else begin
               cmd.cell_zero = 1'b1;
               pend_in       = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_READ: begin
            cmd.rd_capture = 1'b1;
            pend_in        = 1'b1;
            state_in       = ST_IDLE;
         end
         ST_SCROLL: begin
            cmd.sweep_scroll = 1'b1;
            if (status.sweep_last) begin
               cmd.scroll_home = 1'b1;
               state_in        = ST_EXEC;
            end
         end
         ST_CLEAR: begin
            cmd.sweep_blank = 1'b1;
            if (status.sweep_last) begin
               cmd.clear_home = 1'b1;
               cmd.cell_zero  = 1'b1;
               pend_in        = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   assign req_ready = ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

endmodule

FILE: hw/rtl/tcw_datapath.sv
// Datapath for the text console writer: item and cursor registers, screen
// memory with sweep pointer and write stage, result register. Depends on tcw_pkg.
module tcw_datapath import tcw_pkg::*; #(
   parameter int COLUMNS = COLUMNS_DEFAULT,
   parameter int ROWS    = ROWS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [ACTION_W-1:0] req_action,
   input  logic [CHAR_W-1:0]   req_char_code,
   input  logic [ATTR_W-1:0]   req_attribute,
   input  logic [RROW_W-1:0]   req_read_row,
   input  logic [RCOL_W-1:0]   req_read_col,
   input  cmd_type             cmd,
   output status_type          status,
   tcw_rsp_if.source           rsp_if
);

   localparam int CELLS = COLUMNS * ROWS;
   localparam int CW    = $clog2(COLUMNS);
   localparam int CWX   = CW + 1;
   localparam int RW    = $clog2(ROWS + 1);
   localparam int AW    = $clog2(CELLS);
   localparam int OW    = $clog2(CELLS + 1);
   localparam logic [CWX-1:0] COLS_X   = CWX'(COLUMNS);
   localparam logic [OW-1:0]  COLS_O   = OW'(COLUMNS);
   localparam logic [AW-1:0]  COPY_END = AW'(CELLS - COLUMNS);

   // item registers
   logic [ACTION_W-1:0] item_action_ff;
   logic [CHAR_W-1:0]   item_char_ff;
   logic [ATTR_W-1:0]   item_attr_ff;
   logic [RROW_W-1:0]   item_rrow_ff;
   logic [RCOL_W-1:0]   item_rcol_ff;

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         item_action_ff <= req_action;
         item_char_ff   <= req_char_code;
         item_attr_ff   <= req_attribute;
         item_rrow_ff   <= req_read_row;
         item_rcol_ff   <= req_read_col;
      end
   end

   // cursor
   logic [CW-1:0]  col_ff, col_in;
   logic [RW-1:0]  row_ff, row_in;
   logic [CWX-1:0] col_x, col_nxt;
   logic [CW-1:0]  put_col;
   logic [RW-1:0]  put_row;
   logic           put_write;
   logic [OW-1:0]  cur_lin, rd_lin;

   always_comb begin
      col_x     = {1'b0, col_ff};
      put_write = (item_char_ff != NL_CODE) && (item_char_ff != TAB_CODE);
      if (item_char_ff == TAB_CODE) begin
         col_nxt = col_x + CWX'(TAB_STOP) - (col_x & CWX'(TAB_STOP - 1));
      end else begin
         col_nxt = col_x + CWX'(1);
      end
      if (item_char_ff == NL_CODE || col_nxt >= COLS_X) begin
         put_col = '0;
         put_row = row_ff + RW'(1);
      end else begin
         put_col = CW'(col_nxt);
         put_row = row_ff;
      end
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (cmd.put) begin
         col_in = put_col;
         row_in = put_row;
      end else if (cmd.scroll_home) begin
         col_in = '0;
         row_in = RW'(ROWS - 1);
      end else if (cmd.clear_home) begin
         col_in = '0;
         row_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign cur_lin = OW'(col_ff) + OW'(row_ff) * COLS_O;
   assign rd_lin  = OW'(item_rcol_ff) + OW'(item_rrow_ff) * COLS_O;

   // sweep pointer
   logic [AW-1:0] ptr_ff, ptr_in;
   logic          sweep_on, sweep_last, copy_phase;

   assign sweep_on   = cmd.sweep_blank || cmd.sweep_scroll;
   assign sweep_last = (ptr_ff == AW'(CELLS - 1));
   assign copy_phase = cmd.sweep_scroll && (ptr_ff < COPY_END);

   always_comb begin
      ptr_in = ptr_ff;
      if (sweep_on) begin
         ptr_in = sweep_last ? '0 : ptr_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
      end else begin
         ptr_ff <= ptr_in;
      end
   end

   // screen memory; every write goes through a registered write stage
   logic [CELL_W-1:0] mem [CELLS];
   logic [CELL_W-1:0] rd_data_ff;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic              wr_en_ff, wr_en_in;
   logic [AW-1:0]     wr_addr_ff, wr_addr_in;
   logic [CELL_W-1:0] wr_data_ff, wr_data_in;
   logic              wr_from_rd_ff, wr_from_rd_in;

   assign rd_en   = copy_phase || cmd.rd_issue;
   assign rd_addr = copy_phase ? ptr_ff + AW'(COLUMNS) : AW'(rd_lin);

   assign wr_en_in      = sweep_on || (cmd.put && put_write);
   assign wr_addr_in    = sweep_on ? ptr_ff : AW'(cur_lin);
   assign wr_data_in    = sweep_on ? BLANK_CELL : {item_attr_ff, item_char_ff};
   assign wr_from_rd_in = copy_phase;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_en_ff <= 1'b0;
      end else begin
         wr_en_ff <= wr_en_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_addr_ff    <= wr_addr_in;
      wr_data_ff    <= wr_data_in;
      wr_from_rd_ff <= wr_from_rd_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en_ff) begin
         mem[wr_addr_ff] <= wr_from_rd_ff ? rd_data_ff : wr_data_ff;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // read cell result
   logic [CELL_W-1:0] cell_ff, cell_in;

   always_comb begin
      cell_in = cell_ff;
      if (cmd.cell_zero) begin
         cell_in = '0;
      end else if (cmd.rd_capture) begin
         cell_in = rd_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
   end

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CCOL_W-1:0] rsp_col_ff;
   logic [CROW_W-1:0] rsp_row_ff;
   logic [COFS_W-1:0] rsp_ofs_ff;
   logic [CELL_W-1:0] rsp_cell_ff;
   logic              out_free;

   assign out_free = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_col_ff  <= CCOL_W'(col_ff);
         rsp_row_ff  <= CROW_W'(row_ff);
         rsp_ofs_ff  <= COFS_W'(cur_lin);
         rsp_cell_ff <= cell_ff;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.cursor_column = rsp_col_ff;
   assign rsp_if.cursor_row    = rsp_row_ff;
   assign rsp_if.cursor_offset = rsp_ofs_ff;
   assign rsp_if.cell_char     = rsp_cell_ff[CHAR_W-1:0];
   assign rsp_if.cell_attr     = rsp_cell_ff[CELL_W-1:CHAR_W];

   assign status.act         = item_action_ff;
   assign status.scroll_pend = (row_ff == RW'(ROWS));
   assign status.read_ok     = (int'(item_rrow_ff) < ROWS) && (int'(item_rcol_ff) < COLUMNS);
   assign status.sweep_last  = sweep_last;
   assign status.out_free    = out_free;

endmodule

FILE: hw/rtl/text_console_writer.sv
// Top level of the text console writer: controller plus datapath.
// Depends on tcw_pkg, tcw_if, tcw_ctrl and tcw_datapath.
//
//   channel  dir  handshake                 payload
//   req_if   in   valid/ready, tcw_req_if   action, char_code, attribute, read_row, read_col
//   rsp_if   out  valid/ready, tcw_rsp_if   cursor_column/row/offset, cell_char, cell_attr
//
// Put: transfer, then execute; read: transfer, execute, then registered memory read.
// Clear: transfer, execute, then a sweep of every cell; a put that scrolls adds a sweep,
// both paced by the single write port sweeping the screen memory one cell a cycle.
// After reset a clearing pass over all COLUMNS*ROWS cells (2000 by default) runs
// with req_if.ready low. One item is in flight; the next transfer is taken
// while the previous result still waits in the output register.
module text_console_writer import tcw_pkg::*; #(
   parameter int COLUMNS = COLUMNS_DEFAULT,
   parameter int ROWS    = ROWS_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   tcw_req_if.sink   req_if,
   tcw_rsp_if.source rsp_if
);

   cmd_type    cmd;
   status_type status;
   logic       req_ready;

   assign req_if.ready = req_ready;

   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tcw_datapath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_action    (req_if.action),
      .req_char_code (req_if.char_code),
      .req_attribute (req_if.attribute),
      .req_read_row  (req_if.read_row),
      .req_read_col  (req_if.read_col),
      .cmd           (cmd),
      .status        (status),
      .rsp_if        (rsp_if)
   );

endmodule
